// ===== src/hkv_pkg.sv =====
// Shared types and constants of the hash key-value map.
// Depends on nothing; every other file of the block but hkv_ram imports it.
`timescale 1ns / 1ps

package hkv_pkg;

    // Field widths fixed by the request and result formats.
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 64;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_SWAP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL_A,
        S_EVAL_B,
        S_WRITE_A
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   second_key;
        logic [VALUE_W-1:0] new_value;
    } item_t;

endpackage

// ===== src/hkv_req_if.sv =====
// Request and result channel interfaces of the hash key-value map.
// Depends on hkv_pkg.
`timescale 1ns / 1ps

interface hkv_req_if;
    import hkv_pkg::*;

    logic               valid;
    logic               ready;
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   second_key;
    logic [VALUE_W-1:0] new_value;

    modport source (output valid, op, key, second_key, new_value, input ready);
    modport sink   (input valid, op, key, second_key, new_value, output ready);
endinterface

interface hkv_res_if;
    import hkv_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic [VALUE_W-1:0] value_out;

    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface

// ===== src/hkv_ram.sv =====
// Generic single-port RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module hkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read first port: a read in the cycle of a write returns the old word,
    // and read data shows up in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/hkv_front.sv =====
// Front part: accepts request items into a short queue and derives set indexes.
// Depends on hkv_pkg and hkv_req_if.
`timescale 1ns / 1ps

module hkv_front #(
    parameter int SET_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    hkv_req_if.sink             req,
    input  logic                pop,
    output logic                head_valid,
    output hkv_pkg::item_t      head_item,
    output logic [SET_W-1:0]    head_set_a,
    output logic [SET_W-1:0]    head_set_b
);
    import hkv_pkg::*;

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    item_t                  in_item;

    assign req.ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;

    assign in_item.op         = req.op;
    assign in_item.key        = req.key;
    assign in_item.second_key = req.second_key;
    assign in_item.new_value  = req.new_value;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    // The set of a key is its low bits.
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign head_set_a = head_item.key[SET_W-1:0];
    assign head_set_b = head_item.second_key[SET_W-1:0];
endmodule

// ===== src/hkv_back.sv =====
// Back part: runs each item against the set-associative store and holds the result.
// Depends on hkv_pkg, hkv_req_if (result interface) and hkv_ram.
`timescale 1ns / 1ps

module hkv_back #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  hkv_pkg::item_t             head_item,
    input  logic [$clog2(BUCKETS)-1:0] head_set_a,
    input  logic [$clog2(BUCKETS)-1:0] head_set_b,
    output logic                       pop,
    hkv_res_if.source                  res
);
    import hkv_pkg::*;

    localparam int SET_W = $clog2(BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KROW_W = WAYS * KEY_W;
    localparam int VROW_W = WAYS * VALUE_W;

    state_t              state_reg, state_next;
    logic [SET_W-1:0]    clr_reg, clr_next;
    item_t               item_reg, item_next;
    logic [SET_W-1:0]    set_a_reg, set_a_next;
    logic [SET_W-1:0]    set_b_reg, set_b_next;
    logic [WAY_W-1:0]    way_a_reg, way_a_next;
    logic [VROW_W-1:0]   row_a_reg, row_a_next;
    logic [VALUE_W-1:0]  swap_val_reg, swap_val_next;
    logic                res_valid_reg, res_valid_next;
    status_t             res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;

    logic [SET_W-1:0]    addr;
    logic                key_we, val_we, vld_we;
    logic [KROW_W-1:0]   key_wd, key_rd;
    logic [VROW_W-1:0]   val_wd, val_rd;
    logic [WAYS-1:0]     vld_wd, vld_rd;

    logic                hit_a, hit_b, free_any;
    logic [WAY_W-1:0]    way_a, way_b, free_way;
    logic [VALUE_W-1:0]  val_a, val_b, val_saved_a;

    // Set rows: one word holds all ways of a set.
    hkv_ram #(.WIDTH(KROW_W), .DEPTH(BUCKETS)) u_key_ram (
        .clk(clk), .we(key_we), .addr(addr), .wdata(key_wd), .rdata(key_rd)
    );
    hkv_ram #(.WIDTH(VROW_W), .DEPTH(BUCKETS)) u_val_ram (
        .clk(clk), .we(val_we), .addr(addr), .wdata(val_wd), .rdata(val_rd)
    );
    hkv_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_vld_ram (
        .clk(clk), .we(vld_we), .addr(addr), .wdata(vld_wd), .rdata(vld_rd)
    );

    // Way match for both keys and the lowest free way of the row just read.
    always_comb
    begin
        hit_a    = 1'b0;
        hit_b    = 1'b0;
        free_any = 1'b0;
        way_a    = '0;
        way_b    = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_a && vld_rd[w] && key_rd[w*KEY_W +: KEY_W] == item_reg.key)
            begin
                hit_a = 1'b1;
                way_a = WAY_W'(w);
            end
            if (!hit_b && vld_rd[w] && key_rd[w*KEY_W +: KEY_W] == item_reg.second_key)
            begin
                hit_b = 1'b1;
                way_b = WAY_W'(w);
            end
            if (!free_any && !vld_rd[w])
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    assign val_a       = val_rd[int'(way_a)*VALUE_W +: VALUE_W];
    assign val_b       = val_rd[int'(way_b)*VALUE_W +: VALUE_W];
    assign val_saved_a = row_a_reg[int'(way_a_reg)*VALUE_W +: VALUE_W];

    // Sequencer: next state, memory port and result register.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        item_next       = item_reg;
        set_a_next      = set_a_reg;
        set_b_next      = set_b_reg;
        way_a_next      = way_a_reg;
        row_a_next      = row_a_reg;
        swap_val_next   = swap_val_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        pop             = 1'b0;
        addr            = set_a_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        vld_we          = 1'b0;
        key_wd          = key_rd;
        val_wd          = val_rd;
        vld_wd          = vld_rd;

        case (state_reg)
            S_CLEAR:
            begin
                addr     = clr_reg;
                vld_we   = 1'b1;
                vld_wd   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SET_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head_valid && (!res_valid_reg || res.ready))
                begin
                    pop        = 1'b1;
                    addr       = head_set_a;
                    item_next  = head_item;
                    set_a_next = head_set_a;
                    set_b_next = head_set_b;
                    state_next = S_EVAL_A;
                end
            end
            S_EVAL_A:
            begin
                res_status_next = ST_OK;
                res_value_next  = '0;
                res_valid_next  = 1'b1;
                state_next      = S_IDLE;
                case (item_reg.op)
                    OP_INSERT:
                    begin
                        if (hit_a)
                        begin
                            val_wd[int'(way_a)*VALUE_W +: VALUE_W] = item_reg.new_value;
                            val_we = 1'b1;
                        end
                        else if (free_any)
                        begin
                            key_wd[int'(free_way)*KEY_W +: KEY_W]     = item_reg.key;
                            val_wd[int'(free_way)*VALUE_W +: VALUE_W] = item_reg.new_value;
                            vld_wd[free_way] = 1'b1;
                            key_we = 1'b1;
                            val_we = 1'b1;
                            vld_we = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit_a)
                        begin
                            res_value_next = val_a;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (hit_a)
                        begin
                            res_value_next = val_a;
                            vld_wd[way_a]  = 1'b0;
                            vld_we         = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (hit_a)
                        begin
                            // Keep the first row and fetch the second key's set.
                            res_valid_next = res_valid_reg && !res.ready;
                            way_a_next     = way_a;
                            row_a_next     = val_rd;
                            addr           = set_b_reg;
                            state_next     = S_EVAL_B;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_EVAL_B:
            begin
                addr            = set_b_reg;
                res_status_next = ST_OK;
                res_value_next  = '0;
                res_valid_next  = 1'b1;
                state_next      = S_IDLE;
                if (!hit_b)
                begin
                    res_status_next = ST_NOT_FOUND;
                end
                else if (set_a_reg == set_b_reg)
                begin
                    // Both keys share a row: exchange within one write.
                    val_wd[int'(way_b)*VALUE_W +: VALUE_W]     = val_saved_a;
                    val_wd[int'(way_a_reg)*VALUE_W +: VALUE_W] = val_b;
                    val_we = 1'b1;
                end
                else
                begin
                    val_wd[int'(way_b)*VALUE_W +: VALUE_W] = val_saved_a;
                    val_we         = 1'b1;
                    swap_val_next  = val_b;
                    res_valid_next = res_valid_reg && !res.ready;
                    state_next     = S_WRITE_A;
                end
            end
            S_WRITE_A:
            begin
                addr   = set_a_reg;
                val_wd = row_a_reg;
                val_wd[int'(way_a_reg)*VALUE_W +: VALUE_W] = swap_val_reg;
                val_we          = 1'b1;
                res_status_next = ST_OK;
                res_value_next  = '0;
                res_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Work and result payload registers.
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        set_a_reg      <= set_a_next;
        set_b_reg      <= set_b_next;
        way_a_reg      <= way_a_next;
        row_a_reg      <= row_a_next;
        swap_val_reg   <= swap_val_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
    end

    assign res.valid     = res_valid_reg;
    assign res.status    = res_status_reg;
    assign res.value_out = res_value_reg;

    // No item leaves the queue before the valid bits are cleared.
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !pop)
        else $error("item taken during clearing pass");

    // A separate second write only happens for keys in different sets.
    a_write_a_split: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE_A |-> set_a_reg != set_b_reg)
        else $error("split swap write on a shared set");

    // A full-set status only answers an insert.
    a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_status_reg == ST_FULL |-> item_reg.op == OP_INSERT)
        else $error("set full reported for a non-insert item");

    // A new result only comes out of an evaluation or write step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == S_EVAL_A
            || $past(state_reg) == S_EVAL_B || $past(state_reg) == S_WRITE_A))
        else $error("result raised outside an evaluation step");
endmodule

// ===== src/hash_key_value_map.sv =====
// Top level of the hash key-value map: request queue front and store back.
// Depends on hkv_pkg, hkv_req_if, hkv_front, hkv_back and hkv_ram.
//
// Usage:
// Requests arrive on req (op, key, second_key, new_value); one result per
// request leaves on res (status, value_out), in request order. Both channels
// move an item when valid and ready are high at a rising clock edge.
// The store holds BUCKETS sets of WAYS entries; a key lives in the set given
// by its low bits, so BUCKETS must be a power of two.
// An accepted request waits in the queue; the back then takes it, reads the
// key's set row and registers the result. A swap also reads the second key's
// set and, for keys in different sets, writes the two rows one after the other.
// The back serves one item at a time and takes none before the last is done;
// the set RAMs are single-port, and a swap reads two rows and may write two.
// After reset the block clears the valid bits of all BUCKETS sets
// (256 by default); requests queue up (two deep) but none is served until
// the pass ends. A stalled receiver holds the result in its register; the
// queue keeps taking requests until it is full.
`timescale 1ns / 1ps

module hash_key_value_map #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    hkv_req_if.sink   req,
    hkv_res_if.source res
);
    import hkv_pkg::*;

    localparam int SET_W = $clog2(BUCKETS);

    logic             head_valid;
    logic             pop;
    item_t            head_item;
    logic [SET_W-1:0] head_set_a;
    logic [SET_W-1:0] head_set_b;

    hkv_front #(.SET_W(SET_W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_set_a (head_set_a),
        .head_set_b (head_set_b)
    );

    hkv_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_set_a (head_set_a),
        .head_set_b (head_set_b),
        .pop        (pop),
        .res        (res)
    );
endmodule
